FILE: rtl/core/rpbm_pkg.sv
// Package with shared types and constants for the RGB pixel blend pipeline.
`timescale 1ns / 1ps
`default_nettype none

package rpbm_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned SqW = 2 * ChanW;
  localparam int unsigned ProdW = 2 * ChanW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;
  localparam logic [ChanW-1:0] MixRatioReset = 8'd128;

  localparam logic [CfgIdxW-1:0] CfgIdxMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxRatio = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxAlphaEn = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxGray = 2'd3;

  typedef enum logic [2:0] {
    ModeDirect   = 3'd0,
    ModeMinimum  = 3'd1,
    ModeMaximum  = 3'd2,
    ModeMix      = 3'd3,
    ModeTransBlk = 3'd4,
    ModeAdd      = 3'd5,
    ModeSubtract = 3'd6,
    ModeMultiply = 3'd7
  } blend_mode_e;

  typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;

  typedef struct packed {
    pixel_t                        dst;
    pixel_t                        src;
    logic [ChanW-1:0]              alpha;
    logic [NumChan-1:0][SqW-1:0]   sq_dst;
    logic [NumChan-1:0][SqW-1:0]   sq_src;
    logic [NumChan-1:0][ProdW-1:0] mix_sum;
    pixel_t                        mul;
    pixel_t                        add_sat;
    pixel_t                        sub_flr;
  } front_t;

  typedef struct packed {
    pixel_t           dst;
    pixel_t           blend;
    logic [ChanW-1:0] alpha;
  } select_t;

  typedef struct packed {
    pixel_t                        dst;
    logic [NumChan-1:0][ProdW-1:0] mixed;
  } alpha_t;

  typedef struct packed {
    blend_mode_e      mode;
    logic [ChanW-1:0] mix_ratio;
    logic             alpha_en;
    logic             gray_dst;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/rpbm_front.sv
// First pipeline stage: squares, products and per-channel saturating arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module rpbm_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rpbm_pkg::cfg_t    cfg_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire rpbm_pkg::pixel_t  dst_i,
  input  wire rpbm_pkg::pixel_t  src_i,
  input  wire logic [7:0]        alpha_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output rpbm_pkg::front_t       data_o
);

  logic             valid_q;
  rpbm_pkg::front_t data_d;
  rpbm_pkg::front_t data_q;

  always_comb begin
    logic [rpbm_pkg::ChanW-1:0] inv_ratio;
    logic [rpbm_pkg::ChanW:0]   sum;
    logic [rpbm_pkg::ProdW-1:0] prod;
    inv_ratio = rpbm_pkg::ChanMax - cfg_i.mix_ratio;
    data_d.dst = dst_i;
    data_d.src = src_i;
    data_d.alpha = alpha_i;
    for (int i = 0; i < rpbm_pkg::NumChan; i++) begin
      data_d.sq_dst[i] = 16'(dst_i[i]) * 16'(dst_i[i]);
      data_d.sq_src[i] = 16'(src_i[i]) * 16'(src_i[i]);
      data_d.mix_sum[i] = 16'(cfg_i.mix_ratio) * 16'(src_i[i]) +
                          16'(inv_ratio) * 16'(dst_i[i]);
      prod = 16'(dst_i[i]) * 16'(src_i[i]);
      data_d.mul[i] = prod[15:8];
      sum = {1'b0, dst_i[i]} + {1'b0, src_i[i]};
      data_d.add_sat[i] = sum[rpbm_pkg::ChanW] ? rpbm_pkg::ChanMax : sum[7:0];
      data_d.sub_flr[i] = (dst_i[i] > src_i[i]) ? 8'(dst_i[i] - src_i[i]) : 8'd0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/rpbm_select.sv
// Second pipeline stage: brightness compare, mix scaling and blend mode selection.
`timescale 1ns / 1ps
`default_nettype none

module rpbm_select (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rpbm_pkg::cfg_t    cfg_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire rpbm_pkg::front_t  data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output rpbm_pkg::select_t      data_o
);

  logic              valid_q;
  rpbm_pkg::select_t data_d;
  rpbm_pkg::select_t data_q;

  always_comb begin
    logic [rpbm_pkg::SqW+1:0]   len_dst;
    logic [rpbm_pkg::SqW+1:0]   len_src;
    logic                       take_src;
    logic                       per_chan;
    logic [rpbm_pkg::ProdW:0]   mix_q;
    rpbm_pkg::pixel_t           chan;
    len_dst = 18'(data_i.sq_dst[0]) + 18'(data_i.sq_dst[1]) + 18'(data_i.sq_dst[2]);
    len_src = 18'(data_i.sq_src[0]) + 18'(data_i.sq_src[1]) + 18'(data_i.sq_src[2]);
    take_src = 1'b0;
    per_chan = 1'b0;
    chan = data_i.src;
    case (cfg_i.mode)
      rpbm_pkg::ModeDirect:   take_src = 1'b1;
      rpbm_pkg::ModeMinimum:  take_src = len_dst > len_src;
      rpbm_pkg::ModeMaximum:  take_src = len_dst < len_src;
      rpbm_pkg::ModeTransBlk: take_src = |data_i.src;
      default:                per_chan = 1'b1;
    endcase
    for (int i = 0; i < rpbm_pkg::NumChan; i++) begin
      // Division by 255 for values up to 255 * 255, done by reciprocal approximation and truncation.
      mix_q = 17'(data_i.mix_sum[i]) + 17'(data_i.mix_sum[i][15:8]) + 17'd1;
      case (cfg_i.mode)
        rpbm_pkg::ModeMix:      chan[i] = mix_q[15:8];
        rpbm_pkg::ModeAdd:      chan[i] = data_i.add_sat[i];
        rpbm_pkg::ModeSubtract: chan[i] = data_i.sub_flr[i];
        rpbm_pkg::ModeMultiply: chan[i] = data_i.mul[i];
        default:                chan[i] = data_i.src[i];
      endcase
    end
    data_d.dst = data_i.dst;
    data_d.alpha = data_i.alpha;
    if (per_chan) begin
      data_d.blend = chan;
    end else if (take_src) begin
      data_d.blend = data_i.src;
    end else begin
      data_d.blend = data_i.dst;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/rpbm_alpha.sv
// Third and fourth pipeline stages: alpha post-blend products and output register.
`timescale 1ns / 1ps
`default_nettype none

module rpbm_alpha (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rpbm_pkg::cfg_t     cfg_i,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire rpbm_pkg::select_t  data_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output rpbm_pkg::pixel_t        pixel_o
);

  logic             mul_valid_q;
  logic             mul_ready;
  rpbm_pkg::alpha_t mul_d;
  rpbm_pkg::alpha_t mul_q;
  logic             out_valid_q;
  rpbm_pkg::pixel_t out_d;
  rpbm_pkg::pixel_t out_q;

  always_comb begin
    logic [rpbm_pkg::ChanW-1:0] inv_alpha;
    inv_alpha = rpbm_pkg::ChanMax - data_i.alpha;
    mul_d.dst = data_i.dst;
    for (int i = 0; i < rpbm_pkg::NumChan; i++) begin
      if (cfg_i.alpha_en) begin
        mul_d.mixed[i] = 16'(inv_alpha) * 16'(data_i.blend[i]) +
                         16'(data_i.alpha) * 16'(data_i.dst[i]);
      end else begin
        mul_d.mixed[i] = {data_i.blend[i], 8'd0};
      end
    end
  end

  always_comb begin
    out_d[0] = mul_q.mixed[0][15:8];
    for (int i = 1; i < rpbm_pkg::NumChan; i++) begin
      out_d[i] = cfg_i.gray_dst ? mul_q.dst[i] : mul_q.mixed[i][15:8];
    end
  end

  assign mul_ready = !out_valid_q || ready_i;
  assign ready_o = !mul_valid_q || mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        mul_valid_q <= valid_i;
      end
      if (mul_ready) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mul_q <= mul_d;
    end
    if (mul_ready && mul_valid_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign pixel_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/rgb_pixel_blend_modes.sv
// Top level of the RGB pixel blend pipeline with its configuration registers.
// Throughput: one pixel per cycle while the output is ready.
// Every stage holds its item under back-pressure.
// The four register stages are products, mode selection, alpha products and output.
// Reset clears all stage valid bits and loads mode direct, mix ratio 128,
// alpha off and color destination.
`timescale 1ns / 1ps
`default_nettype none

module rgb_pixel_blend_modes (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] dest_red_i,
  input  wire logic [7:0] dest_green_i,
  input  wire logic [7:0] dest_blue_i,
  input  wire logic [7:0] src_red_i,
  input  wire logic [7:0] src_green_i,
  input  wire logic [7:0] src_blue_i,
  input  wire logic [7:0] src_alpha_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_red_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_blue_o
);

  rpbm_pkg::cfg_t    cfg_q;
  rpbm_pkg::pixel_t  dst;
  rpbm_pkg::pixel_t  src;
  rpbm_pkg::pixel_t  result;
  rpbm_pkg::front_t  front_data;
  rpbm_pkg::select_t sel_data;
  logic              front_valid;
  logic              front_ready;
  logic              sel_valid;
  logic              sel_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= rpbm_pkg::ModeDirect;
      cfg_q.mix_ratio <= rpbm_pkg::MixRatioReset;
      cfg_q.alpha_en <= 1'b0;
      cfg_q.gray_dst <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpbm_pkg::CfgIdxMode:    cfg_q.mode <= rpbm_pkg::blend_mode_e'(cfg_wdata_i[2:0]);
        rpbm_pkg::CfgIdxRatio:   cfg_q.mix_ratio <= cfg_wdata_i;
        rpbm_pkg::CfgIdxAlphaEn: cfg_q.alpha_en <= cfg_wdata_i[0];
        rpbm_pkg::CfgIdxGray:    cfg_q.gray_dst <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign dst = {dest_blue_i, dest_green_i, dest_red_i};
  assign src = {src_blue_i, src_green_i, src_red_i};

  rpbm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .dst_i   (dst),
    .src_i   (src),
    .alpha_i (src_alpha_i),
    .valid_o (front_valid),
    .ready_i (front_ready),
    .data_o  (front_data)
  );

  rpbm_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .data_i  (front_data),
    .valid_o (sel_valid),
    .ready_i (sel_ready),
    .data_o  (sel_data)
  );

  rpbm_alpha u_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (sel_valid),
    .ready_o (sel_ready),
    .data_i  (sel_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .pixel_o (result)
  );

  assign out_red_o = result[0];
  assign out_green_o = result[1];
  assign out_blue_o = result[2];

endmodule

`default_nettype wire
